// File: rtl/sbtc_pkg.sv
// ----------------------------------------------------------------------------
// sbtc_pkg
// Shared types and constants for the six-bit text codec.
// ----------------------------------------------------------------------------
package sbtc_pkg;

  // Offset added to every 6-bit value to make a printable character
  localparam logic [7:0] CHAR_BASE = 8'h3c;

  // Codec direction
  typedef enum logic {
    DIR_ENCODE = 1'b0,
    DIR_DECODE = 1'b1
  } dir_e;

  // One result beat
  typedef struct packed {
    logic [7:0] data;
    logic       has_data;
    logic       last;
    logic       bad_char;
  } res_t;

  // Up to two results produced by one input item
  typedef struct packed {
    res_t       r0;
    res_t       r1;
    logic [1:0] num;
  } res_pair_t;

  // Per-message state
  typedef struct packed {
    logic [1:0] group_phase;
    logic [7:0] carry_bits;
    logic       failed;
  } msg_state_t;

endpackage

// File: rtl/six_bit_text_codec.sv
// ----------------------------------------------------------------------------
// six_bit_text_codec
// Six-bit printable text codec (offset 0x3c), encode or decode by register.
// ----------------------------------------------------------------------------
// Datapath: input register, then result register. Items are paced by the
//   single result port draining the result slots; an item waits in the input
//   register until the slots are free, and may load as the last result leaves.
// Reset: asynchronous active low; clears direction to encode, message state
//   and all valid flags.
module six_bit_text_codec (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Configuration: direction
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  // Input stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_in
  input  logic       s_axis_tlast,
  // Output stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] data_out
  output logic [1:0] m_axis_tuser,   // [0] has_data, [1] bad_char
  output logic       m_axis_tlast
);
  import sbtc_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_data_q;
  logic       in_last_q;
  logic       out_free;
  logic       step;
  logic [1:0] out_cnt;
  res_pair_t  pair;
  res_t       res;

  assign step          = in_valid_q & out_free;
  assign s_axis_tready = ~in_valid_q | out_free;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  sbtc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .data_i      (in_data_q),
    .last_i      (in_last_q),
    .pair_o      (pair)
  );

  sbtc_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step),
    .pair_i  (pair),
    .free_o  (out_free),
    .count_o (out_cnt),
    .res_o   (res),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready)
  );

  assign m_axis_tdata = res.data;
  assign m_axis_tuser = {res.bad_char, res.has_data};
  assign m_axis_tlast = res.last;

  // Result slots never overfill
  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_cnt != 2'd3)
    else $error("result slot count out of range");

  // A waiting input item is never dropped
  a_in_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_free) |=> in_valid_q)
    else $error("input item lost while stalled");

  // Error flag appears only on an end-only marker
  a_bad_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tlast && !m_axis_tuser[0]))
    else $error("bad_char on a non-marker result");

  // Slots are loaded only once the previous results are drained
  a_load_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && out_cnt == 2'd2) |-> 1'b0)
    else $error("result slots overwritten");

endmodule

// File: rtl/sbtc_core.sv
// ----------------------------------------------------------------------------
// sbtc_core
// Direction register, message state and the per-item encode/decode step.
// ----------------------------------------------------------------------------
module sbtc_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                step_i,
  input  logic [7:0]          data_i,
  input  logic                last_i,
  output sbtc_pkg::res_pair_t pair_o
);
  import sbtc_pkg::*;

  dir_e       dir_q;
  msg_state_t st_q, st_d;

  logic [5:0] made;
  logic [5:0] rest;
  logic [5:0] dec_v;
  logic       fail_n;
  logic       have;
  logic [7:0] dec_byte;

  // Compute results and next state for the item in the input register
  always_comb begin
    pair_o   = '0;
    st_d     = st_q;
    made     = '0;
    rest     = '0;
    dec_v    = 6'(data_i - CHAR_BASE);
    fail_n   = st_q.failed | (data_i < CHAR_BASE);
    have     = 1'b0;
    dec_byte = '0;

    if (dir_q == DIR_ENCODE) begin
      case (st_q.group_phase)
        2'd0: begin
          made = data_i[7:2];
          rest = {data_i[1:0], 4'b0000};
        end
        2'd1: begin
          made = st_q.carry_bits[5:0] | {2'b00, data_i[7:4]};
          rest = {data_i[3:0], 2'b00};
        end
        default: begin
          made = st_q.carry_bits[5:0] | {4'b0000, data_i[7:6]};
          rest = data_i[5:0];
        end
      endcase
      pair_o.r0.data     = {2'b00, made} + CHAR_BASE;
      pair_o.r0.has_data = 1'b1;
      pair_o.r1.data     = {2'b00, rest} + CHAR_BASE;
      pair_o.r1.has_data = 1'b1;
      if (st_q.group_phase[1] == 1'b0) begin
        // Partial group: flush leftover bits only on the last byte
        st_d.group_phase = st_q.group_phase + 2'd1;
        st_d.carry_bits  = {2'b00, rest};
        pair_o.num       = last_i ? 2'd2 : 2'd1;
        pair_o.r1.last   = last_i;
      end else begin
        // Group complete: two characters out
        st_d.group_phase = '0;
        st_d.carry_bits  = '0;
        pair_o.num       = 2'd2;
        pair_o.r1.last   = last_i;
      end
      if (last_i) begin
        st_d = '0;
      end
    end else begin
      st_d.failed = fail_n;
      if (!fail_n) begin
        case (st_q.group_phase)
          2'd0: begin
            st_d.carry_bits  = {dec_v, 2'b00};
            st_d.group_phase = 2'd1;
          end
          2'd1: begin
            dec_byte         = st_q.carry_bits | {6'b000000, dec_v[5:4]};
            have             = 1'b1;
            st_d.carry_bits  = {dec_v[3:0], 4'b0000};
            st_d.group_phase = 2'd2;
          end
          2'd2: begin
            dec_byte         = st_q.carry_bits | {4'b0000, dec_v[5:2]};
            have             = 1'b1;
            st_d.carry_bits  = {dec_v[1:0], 6'b000000};
            st_d.group_phase = 2'd3;
          end
          default: begin
            dec_byte         = st_q.carry_bits | {2'b00, dec_v};
            have             = 1'b1;
            st_d.carry_bits  = '0;
            st_d.group_phase = 2'd0;
          end
        endcase
      end
      if (last_i) begin
        // Last item always ends with exactly one result
        pair_o.num         = 2'd1;
        pair_o.r0.last     = 1'b1;
        pair_o.r0.bad_char = fail_n;
        pair_o.r0.has_data = have;
        pair_o.r0.data     = have ? dec_byte : 8'h00;
        st_d               = '0;
      end else begin
        pair_o.num         = {1'b0, have};
        pair_o.r0.has_data = 1'b1;
        pair_o.r0.data     = dec_byte;
      end
    end
  end

  // Direction register; any write starts a new message
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= DIR_ENCODE;
      st_q  <= '0;
    end else if (cfg_we_i) begin
      dir_q <= dir_e'(cfg_wdata_i);
      st_q  <= '0;
    end else if (step_i) begin
      st_q  <= st_d;
    end
  end

endmodule

// File: rtl/sbtc_out.sv
// ----------------------------------------------------------------------------
// sbtc_out
// Two-slot result register that drains one result beat per cycle while the output is ready.
// ----------------------------------------------------------------------------
module sbtc_out (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  sbtc_pkg::res_pair_t pair_i,
  output logic                free_o,
  output logic [1:0]          count_o,
  output sbtc_pkg::res_t      res_o,
  output logic                valid_o,
  input  logic                ready_i
);
  import sbtc_pkg::*;

  res_t       slot0_q, slot0_d;
  res_t       slot1_q, slot1_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign valid_o = (cnt_q != 2'd0);
  assign pop     = valid_o & ready_i;
  // Empty by the next edge: safe to load a new pair
  assign free_o  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && ready_i);
  assign res_o   = slot0_q;
  assign count_o = cnt_q;

  // Load a new pair or shift the second slot forward
  always_comb begin
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    cnt_d   = cnt_q;
    if (load_i) begin
      slot0_d = pair_i.r0;
      slot1_d = pair_i.r1;
      cnt_d   = pair_i.num;
    end else if (pop) begin
      slot0_d = slot1_q;
      cnt_d   = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

endmodule

// File: bench/six_bit_text_codec_tb.sv
// ----------------------------------------------------------------------------
// six_bit_text_codec_tb
// Self-checking bench for the six-bit text codec. Drives byte and character
// messages in both directions, predicts every result beat from its own copy
// of the codec state, and compares each output beat field by field. Both
// stream sides stall at random, with one long stretch of full-rate traffic.
// ----------------------------------------------------------------------------
module six_bit_text_codec_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sbtc_pkg::*;

  localparam int RANDOM_ITEMS = 600;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int SETTLE_WAIT  = 10;
  localparam int GAP_PERCENT  = 33;
  localparam int REPORT_MAX   = 10;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       cfg_we_i      = 1'b0;
  logic       cfg_wdata_i   = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;  // [7:0] data_in
  logic       s_axis_tlast  = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [7:0] data_out
  logic [1:0] m_axis_tuser;           // [0] has_data, [1] bad_char
  logic       m_axis_tlast;

  // Predicted codec state
  dir_e       pred_dir;
  logic [1:0] pred_phase;
  logic [7:0] pred_carry;
  logic       pred_failed;

  res_t codec_out_due[$];
  int   fail_count = 0;
  int   cycle_count = 0;
  bit   no_gaps = 1'b0;

  six_bit_text_codec DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic void clear_message();
    pred_phase  = 2'd0;
    pred_carry  = 8'h00;
    pred_failed = 1'b0;
  endfunction

  function automatic void owe_beat(input logic [7:0] data, input logic has,
                                   input logic lst, input logic bad);
    res_t r;
    r.data     = data;
    r.has_data = has;
    r.last     = lst;
    r.bad_char = bad;
    codec_out_due.push_back(r);
  endfunction

  // Advance the predicted codec by one accepted beat and queue its results
  function automatic void run_codec(input logic [7:0] b, input logic lst);
    logic [5:0] made;
    logic [5:0] rest;
    logic [5:0] v;
    logic [7:0] rebuilt;
    logic       have;
    if (pred_dir == DIR_ENCODE) begin
      case (pred_phase)
        2'd0: begin
          made = b[7:2];
          rest = {b[1:0], 4'b0000};
        end
        2'd1: begin
          made = pred_carry[5:0] | {2'b00, b[7:4]};
          rest = {b[3:0], 2'b00};
        end
        default: begin
          made = pred_carry[5:0] | {4'b0000, b[7:6]};
          rest = b[5:0];
        end
      endcase
      if (pred_phase < 2'd2) begin
        owe_beat({2'b00, made} + CHAR_BASE, 1'b1, 1'b0, 1'b0);
        pred_phase = pred_phase + 2'd1;
        pred_carry = {2'b00, rest};
        if (lst) begin
          owe_beat(pred_carry + CHAR_BASE, 1'b1, 1'b1, 1'b0);
          clear_message();
        end
      end else begin
        owe_beat({2'b00, made} + CHAR_BASE, 1'b1, 1'b0, 1'b0);
        owe_beat({2'b00, rest} + CHAR_BASE, 1'b1, lst, 1'b0);
        clear_message();
      end
    end else begin
      have    = 1'b0;
      rebuilt = 8'h00;
      if (!pred_failed && b < CHAR_BASE) pred_failed = 1'b1;
      if (!pred_failed) begin
        v = 6'(b - CHAR_BASE);
        case (pred_phase)
          2'd0: begin
            pred_carry = {v, 2'b00};
            pred_phase = 2'd1;
          end
          2'd1: begin
            rebuilt    = pred_carry | {6'b0, v[5:4]};
            have       = 1'b1;
            pred_carry = {v[3:0], 4'b0000};
            pred_phase = 2'd2;
          end
          2'd2: begin
            rebuilt    = pred_carry | {4'b0, v[5:2]};
            have       = 1'b1;
            pred_carry = {v[1:0], 6'b0};
            pred_phase = 2'd3;
          end
          default: begin
            rebuilt    = pred_carry | {2'b00, v};
            have       = 1'b1;
            pred_carry = 8'h00;
            pred_phase = 2'd0;
          end
        endcase
      end
      if (lst) begin
        if (pred_failed)   owe_beat(8'h00, 1'b0, 1'b1, 1'b1);
        else if (have)     owe_beat(rebuilt, 1'b1, 1'b1, 1'b0);
        else               owe_beat(8'h00, 1'b0, 1'b1, 1'b0);
        clear_message();
      end else if (have) begin
        owe_beat(rebuilt, 1'b1, 1'b0, 1'b0);
      end
    end
  endfunction

  function automatic void flag_error(input string msg);
    fail_count++;
    if (fail_count <= REPORT_MAX) $display("[%0t] mismatch: %s", $realtime, msg);
  endfunction

  // Compare one output beat with the oldest predicted result
  function automatic void check_out_beat();
    res_t want;
    res_t got;
    got.data     = m_axis_tdata;
    got.has_data = m_axis_tuser[0];
    got.last     = m_axis_tlast;
    got.bad_char = m_axis_tuser[1];
    if (codec_out_due.size() == 0) begin
      flag_error($sformatf("unexpected beat data=%02h has=%b last=%b bad=%b",
                           got.data, got.has_data, got.last, got.bad_char));
    end else begin
      want = codec_out_due.pop_front();
      if (got.data !== want.data || got.has_data !== want.has_data ||
          got.last !== want.last || got.bad_char !== want.bad_char) begin
        flag_error($sformatf(
          "exp data=%02h has=%b last=%b bad=%b, got data=%02h has=%b last=%b bad=%b",
          want.data, want.has_data, want.last, want.bad_char,
          got.data, got.has_data, got.last, got.bad_char));
      end
    end
  endfunction

  // Check output beats and stall the result side at random
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_out_beat();
    m_axis_tready <= no_gaps || ($urandom_range(99) >= GAP_PERCENT);
  end

  // Send one beat, idling first at random; tvalid stays high on return
  task automatic send_item(input logic [7:0] d, input logic lst);
    while (!no_gaps && $urandom_range(99) < GAP_PERCENT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tlast  <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
    run_codec(d, lst);
  endtask

  // Drop the input stream and wait until every predicted result has arrived
  task automatic drain_codec();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (codec_out_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  task automatic write_direction(input dir_e d);
    drain_codec();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= d;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    pred_dir = d;
    clear_message();
  endtask

  // Cover one, two, three and four byte messages with all-zero and all-one bytes
  task automatic test_encode_directed();
    write_direction(DIR_ENCODE);
    send_item(8'h00, 1'b1);
    send_item(8'hff, 1'b0);
    send_item(8'h00, 1'b1);
    send_item(8'hff, 1'b0);
    send_item(8'hff, 1'b0);
    send_item(8'hff, 1'b1);
    send_item(8'h00, 1'b0);
    send_item(8'hff, 1'b0);
    send_item(8'ha5, 1'b0);
    send_item(8'h5a, 1'b1);
  endtask

  // Cover end-only markers, a byte on the last beat and bad characters
  task automatic test_decode_directed();
    write_direction(DIR_DECODE);
    send_item(8'h3c, 1'b1);
    send_item(8'hff, 1'b0);
    send_item(8'h3c, 1'b1);
    send_item(8'h7b, 1'b0);
    send_item(8'hc3, 1'b0);
    send_item(8'h3c, 1'b0);
    send_item(8'hff, 1'b0);
    send_item(8'h7b, 1'b1);
    send_item(8'h41, 1'b0);
    send_item(8'h3b, 1'b0);
    send_item(8'h50, 1'b0);
    send_item(8'hff, 1'b1);
    send_item(8'h00, 1'b1);
  endtask

  // Random messages in phases of random direction; one phase runs at full rate
  task automatic test_random_messages();
    int         counted;
    int         phase_no;
    int         msgs;
    int         len;
    logic [7:0] d;
    logic       lst;
    bit         open_end;
    counted  = 0;
    phase_no = 0;
    while (counted < RANDOM_ITEMS) begin
      write_direction(dir_e'(1'($urandom_range(1))));
      no_gaps = (phase_no == 3);
      msgs = no_gaps ? 20 : $urandom_range(3, 8);
      for (int m = 0; m < msgs; m++) begin
        len      = ($urandom_range(9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
        open_end = (m == msgs - 1) && ($urandom_range(3) == 0);
        for (int i = 0; i < len; i++) begin
          if (pred_dir == DIR_ENCODE)      d = 8'($urandom_range(255));
          else if ($urandom_range(29) == 0) d = 8'($urandom_range(8'h3b));
          else                              d = 8'($urandom_range(255, 8'h3c));
          lst = (i == len - 1) && !open_end;
          if (!(pred_dir == DIR_DECODE && pred_failed)) counted++;
          send_item(d, lst);
        end
      end
      phase_no++;
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    pred_dir = DIR_ENCODE;
    clear_message();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_encode_directed();
    test_decode_directed();
    test_random_messages();
    drain_codec();

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
